[hdl/home_computer_bus_decoder_top_macros.svh]
// Assertion macros used by the checker of the bus decoder.
`ifndef HOME_COMPUTER_BUS_DECODER_TOP_MACROS_SVH
`define HOME_COMPUTER_BUS_DECODER_TOP_MACROS_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define HCBD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bus decoder check failed: same-cycle rule");

// Condition in a cycle implies a consequence in the next cycle.
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bus decoder check failed: next-cycle rule");

`endif

[hdl/hcbd_pkg.sv]
package hcbd_pkg;

  localparam int ADDR_W          = 16;
  localparam int BYTE_W          = 8;
  localparam int KEY_W           = 40;
  localparam int ROW_W           = 5;
  localparam int MASK_W          = 4;
  localparam int REQ_W           = 3;
  localparam int EXT_W           = ADDR_W + 1;

  localparam int ROM_BYTES       = 16384;
  localparam int RAM_BASE        = 16384;
  localparam int RAM_DEPTH       = 49152;
  localparam int CONTENDED_BYTES = 16384;
  localparam int HALF_ROWS       = 8;

  localparam int ROM_AW          = $clog2(ROM_BYTES);
  localparam int RAM_AW          = $clog2(RAM_DEPTH);

  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_AW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [EXT_W-1:0] ROM_LIMIT  = EXT_W'(ROM_BYTES);
  localparam logic [EXT_W-1:0] RAM_START  = EXT_W'(RAM_BASE);
  localparam logic [EXT_W-1:0] RAM_SPAN   = EXT_W'(RAM_DEPTH);
  localparam logic [EXT_W-1:0] CONT_LIMIT = EXT_W'(RAM_BASE + CONTENDED_BYTES);

  localparam logic [ADDR_W-1:0] RAM_FITTED_RESET = 16'd49152;

  localparam logic [BYTE_W-1:0] BUS_IDLE       = 8'hFF;
  localparam logic [ROW_W-1:0]  KEY_ROW_IDLE   = 5'h1F;
  localparam int                ROW_ADDR_LSB   = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_MEM_READ  = 3'd0,
    REQ_MEM_WRITE = 3'd1,
    REQ_IO_READ   = 3'd2,
    REQ_IO_WRITE  = 3'd3,
    REQ_INT_ACK   = 3'd4,
    REQ_ROM_LOAD  = 3'd5
  } req_code_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ROM_READ,
    OP_RAM_READ,
    OP_RAM_WRITE,
    OP_ROM_LOAD,
    OP_KEY_READ,
    OP_VIDEO_WRITE
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [ROM_AW-1:0]  rom_addr;
    logic [RAM_AW-1:0]  ram_addr;
    logic [BYTE_W-1:0]  data;
    logic               contended;
    logic [MASK_W-1:0]  charge_mask;
  } op_entry_t;

endpackage

[hdl/hcbd_front.sv]
module hcbd_front import hcbd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [ADDR_W-1:0] bus_address,
  input  logic [BYTE_W-1:0] write_byte,
  input  logic [KEY_W-1:0]  key_lines,
  input  logic              ear_level,
  output logic              push_valid,
  input  logic              push_ready,
  output op_entry_t         push_entry
);

  logic [ADDR_W-1:0] ram_fitted;
  logic [EXT_W-1:0]  addr_ext;
  logic [ADDR_W-1:0] ram_off;
  logic              in_rom;
  logic              in_ram;
  logic              contended;
  logic              video_port;
  logic [ROW_W-1:0]  key_row;
  logic [BYTE_W-1:0] key_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_fitted <= RAM_FITTED_RESET;
    end else if (cfg_valid) begin
      ram_fitted <= cfg_data;
    end
  end

  assign addr_ext   = {1'b0, bus_address};
  assign ram_off    = bus_address - RAM_START[ADDR_W-1:0];
  assign in_rom     = addr_ext < ROM_LIMIT;
  assign in_ram     = !in_rom && (addr_ext >= RAM_START) && (ram_off < ram_fitted) &&
                      ({1'b0, ram_off} < RAM_SPAN);
  assign contended  = (addr_ext >= RAM_START) && (addr_ext < CONT_LIMIT);
  assign video_port = !bus_address[0];

  // AND the half-rows whose select line in the high address byte is low.
  always_comb begin
    key_row = KEY_ROW_IDLE;
    for (int r = 0; r < HALF_ROWS; r++) begin
      if (!bus_address[ROW_ADDR_LSB + r]) key_row = key_row & key_lines[ROW_W*r +: ROW_W];
    end
    key_byte = {1'b1, ear_level, 1'b1, key_row};
  end

  always_comb begin
    push_entry.rom_addr    = bus_address[ROM_AW-1:0];
    push_entry.ram_addr    = ram_off[RAM_AW-1:0];
    push_entry.data        = write_byte;
    push_entry.contended   = contended;
    push_entry.charge_mask = {contended && !video_port, contended && !video_port,
                              contended || video_port, contended};
    push_entry.kind        = OP_NONE;
    unique case (req_code_t'(req_type))
      REQ_MEM_READ: begin
        if (in_rom) push_entry.kind = OP_ROM_READ;
        else if (in_ram) push_entry.kind = OP_RAM_READ;
      end
      REQ_MEM_WRITE: begin
        if (in_ram) push_entry.kind = OP_RAM_WRITE;
      end
      REQ_IO_READ: begin
        if (video_port) begin
          push_entry.kind = OP_KEY_READ;
          push_entry.data = key_byte;
        end
      end
      REQ_IO_WRITE: begin
        if (video_port) push_entry.kind = OP_VIDEO_WRITE;
      end
      REQ_ROM_LOAD: begin
        if (in_rom) push_entry.kind = OP_ROM_LOAD;
      end
      default: push_entry.kind = OP_NONE;
    endcase
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

[hdl/hcbd_queue.sv]
module hcbd_queue import hcbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  op_entry_t push_entry,
  output logic      pop_valid,
  input  logic      pop_ready,
  output op_entry_t pop_entry
);

  op_entry_t             slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;
  logic                  push;
  logic                  pop;

  assign push_ready = count != QUEUE_CW'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[hdl/hcbd_back.sv]
module hcbd_back import hcbd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  op_entry_t         pop_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] read_byte,
  output logic              video_write_valid,
  output logic [BYTE_W-1:0] video_write_byte,
  output logic              contended_address,
  output logic [MASK_W-1:0] port_charge_mask
);

  logic [BYTE_W-1:0] rom_mem [ROM_BYTES];
  logic [BYTE_W-1:0] ram_mem [RAM_DEPTH];
  logic [BYTE_W-1:0] rom_q;
  logic [BYTE_W-1:0] ram_q;
  op_entry_t         held;
  logic              pop;

  // Advance when the output register is empty or being drained.
  assign pop_ready = !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (pop && pop_entry.kind == OP_ROM_LOAD) rom_mem[pop_entry.rom_addr] <= pop_entry.data;
    if (pop && pop_entry.kind == OP_ROM_READ) rom_q <= rom_mem[pop_entry.rom_addr];
  end

  always_ff @(posedge clk) begin
    if (pop && pop_entry.kind == OP_RAM_WRITE) ram_mem[pop_entry.ram_addr] <= pop_entry.data;
    if (pop && pop_entry.kind == OP_RAM_READ) ram_q <= ram_mem[pop_entry.ram_addr];
  end

  always_ff @(posedge clk) begin
    if (pop) held <= pop_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    unique case (held.kind)
      OP_ROM_READ: read_byte = rom_q;
      OP_RAM_READ: read_byte = ram_q;
      OP_KEY_READ: read_byte = held.data;
      default:     read_byte = BUS_IDLE;
    endcase
  end

  assign video_write_valid = held.kind == OP_VIDEO_WRITE;
  assign video_write_byte  = video_write_valid ? held.data : '0;
  assign contended_address = held.contended;
  assign port_charge_mask  = held.charge_mask;

endmodule

[hdl/home_computer_bus_decoder_top.sv]
// Bus decoder of a small home computer: one bus access per input word.
// Input channel in_valid/in_ready carries req_type, bus_address, write_byte,
// key_lines and ear_level. Memory reads return ROM below the ROM size, fitted
// RAM above the RAM base, and 0xFF elsewhere; writes go to fitted RAM only;
// ROM loads fill the ROM. I/O reads with A0 low return the keyboard byte,
// I/O writes with A0 low are passed out as a video write.
// Output channel out_valid/out_ready gives one result word per input word,
// in order: read_byte, video_write_*, contended_address, port_charge_mask.
// Configuration channel cfg_valid/cfg_ready writes ram_bytes_fitted; write
// it only while no access is in flight.
// A word accepted into the two-word queue is popped into the back end's
// output register and shown from there; the decode front, the queue and
// the memory back end each take one word per cycle while results are
// taken, so throughput is one word per cycle, set by the single ROM or RAM port.
// Reset clears the queue and the output register and sets ram_bytes_fitted
// to 49152; memory contents stay undefined until written.
// When the receiver stalls, the result holds, the queue fills, and in_ready
// falls after two more words.
module home_computer_bus_decoder_top import hcbd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] ram_bytes_fitted,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [ADDR_W-1:0] bus_address,
  input  logic [BYTE_W-1:0] write_byte,
  input  logic [KEY_W-1:0]  key_lines,
  input  logic              ear_level,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] read_byte,
  output logic              video_write_valid,
  output logic [BYTE_W-1:0] video_write_byte,
  output logic              contended_address,
  output logic [MASK_W-1:0] port_charge_mask
);

  logic      push_valid;
  logic      push_ready;
  op_entry_t push_entry;
  logic      pop_valid;
  logic      pop_ready;
  op_entry_t pop_entry;

  hcbd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (ram_bytes_fitted),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .bus_address (bus_address),
    .write_byte  (write_byte),
    .key_lines   (key_lines),
    .ear_level   (ear_level),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_entry  (push_entry)
  );

  hcbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  hcbd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_entry         (pop_entry),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .read_byte         (read_byte),
    .video_write_valid (video_write_valid),
    .video_write_byte  (video_write_byte),
    .contended_address (contended_address),
    .port_charge_mask  (port_charge_mask)
  );

endmodule

[hdl/hcbd_checker.sv]
`include "home_computer_bus_decoder_top_macros.svh"

module hcbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_byte,
  input logic       video_write_valid,
  input logic [7:0] video_write_byte,
  input logic       contended_address,
  input logic [3:0] port_charge_mask
);

  // Hold a stalled result word.
  `HCBD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(read_byte) && $stable(port_charge_mask))

  // A word with no video write carries a zero video byte.
  `HCBD_ASSERT_SAME(a_video_byte_zero, clk, rst, out_valid && !video_write_valid, video_write_byte == 8'h00)

  // A video write never returns read data.
  `HCBD_ASSERT_SAME(a_video_no_read, clk, rst, out_valid && video_write_valid, read_byte == 8'hFF)

  // Low mask bit follows the contended flag; the two high bits move together.
  `HCBD_ASSERT_SAME(a_mask_shape, clk, rst, out_valid, (port_charge_mask[0] == contended_address) && (port_charge_mask[2] == port_charge_mask[3]))

endmodule

bind home_computer_bus_decoder_top hcbd_checker u_checker (.*);

[test/tb_home_computer_bus_decoder_top.sv]
`timescale 1ns / 100ps

import hcbd_pkg::*;

typedef struct packed {
  logic [BYTE_W-1:0] read_byte;
  logic              video_valid;
  logic [BYTE_W-1:0] video_byte;
  logic              contended;
  logic [MASK_W-1:0] charge_mask;
} bus_result_t;

class bus_decode_scoreboard;
  logic [ADDR_W-1:0] ram_fitted;
  logic [BYTE_W-1:0] rom_image [ROM_BYTES];
  logic [BYTE_W-1:0] ram_image [RAM_DEPTH];
  bit                rom_written [ROM_BYTES];
  bit                ram_written [RAM_DEPTH];
  int                rom_filled [$];
  int                ram_filled [$];
  bus_result_t       expected_results [$];
  int                fail_count;
  int                reported;

  function new();
    ram_fitted = RAM_FITTED_RESET;
    fail_count = 0;
    reported   = 0;
  endfunction

  function bit ram_lookup(input logic [ADDR_W-1:0] addr, output int offset);
    offset = int'(addr) - RAM_BASE;
    return int'(addr) >= ROM_BYTES && int'(addr) >= RAM_BASE &&
           offset < int'(ram_fitted) && offset < RAM_DEPTH;
  endfunction

  function bit is_contended(input logic [ADDR_W-1:0] addr);
    return int'(addr) >= RAM_BASE && int'(addr) < RAM_BASE + CONTENDED_BYTES;
  endfunction

  // True when a memory read of addr would return a byte never stored.
  function bit read_hits_blank(input logic [ADDR_W-1:0] addr);
    int offset;
    if (int'(addr) < ROM_BYTES) return !rom_written[addr];
    if (ram_lookup(addr, offset)) return !ram_written[offset];
    return 1'b0;
  endfunction

  function bit stored_address(output logic [ADDR_W-1:0] addr);
    addr = '0;
    if (rom_filled.size() == 0 && ram_filled.size() == 0) return 1'b0;
    if (ram_filled.size() == 0 || (rom_filled.size() != 0 && $urandom_range(0, 1) == 0))
      addr = ADDR_W'(rom_filled[$urandom_range(0, rom_filled.size() - 1)]);
    else
      addr = ADDR_W'(RAM_BASE + ram_filled[$urandom_range(0, ram_filled.size() - 1)]);
    return 1'b1;
  endfunction

  function bus_result_t decode_access(input logic [REQ_W-1:0] req,
                                      input logic [ADDR_W-1:0] addr,
                                      input logic [BYTE_W-1:0] wbyte,
                                      input logic [KEY_W-1:0] keys,
                                      input logic ear);
    bus_result_t res;
    int offset;
    int row;
    logic [ROW_W-1:0] lines;
    logic cont;
    logic video;
    res.read_byte   = BUS_IDLE;
    res.video_valid = 1'b0;
    res.video_byte  = '0;
    case (req)
      REQ_MEM_READ: begin
        if (int'(addr) < ROM_BYTES) res.read_byte = rom_image[addr];
        else if (ram_lookup(addr, offset)) res.read_byte = ram_image[offset];
      end
      REQ_MEM_WRITE: begin
        if (ram_lookup(addr, offset)) begin
          ram_image[offset] = wbyte;
          if (!ram_written[offset]) begin
            ram_written[offset] = 1'b1;
            ram_filled.push_back(offset);
          end
        end
      end
      REQ_IO_READ: begin
        if (!addr[0]) begin
          lines = KEY_ROW_IDLE;
          for (row = 0; row < HALF_ROWS && row < 8; row++) begin
            // a zero address line selects its half-row
            if (!addr[ROW_ADDR_LSB + row]) lines &= keys[ROW_W*row +: ROW_W];
          end
          res.read_byte = {1'b1, ear, 1'b1, lines};
        end
      end
      REQ_IO_WRITE: begin
        if (!addr[0]) begin
          res.video_valid = 1'b1;
          res.video_byte  = wbyte;
        end
      end
      REQ_ROM_LOAD: begin
        if (int'(addr) < ROM_BYTES) begin
          rom_image[addr] = wbyte;
          if (!rom_written[addr]) begin
            rom_written[addr] = 1'b1;
            rom_filled.push_back(int'(addr));
          end
        end
      end
      default: ;
    endcase
    cont  = is_contended(addr);
    video = !addr[0];
    res.contended   = cont;
    res.charge_mask = {cont && !video, cont && !video, cont || video, cont};
    return res;
  endfunction

  function void note_access(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] wbyte, input logic [KEY_W-1:0] keys,
                            input logic ear);
    expected_results.push_back(decode_access(req, addr, wbyte, keys, ear));
  endfunction

  function void check_result(input bus_result_t got);
    bus_result_t want;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (reported < 10) begin
        reported++;
        $display("unexpected result word: rd=%h vwv=%b vwb=%h cont=%b mask=%h",
                 got.read_byte, got.video_valid, got.video_byte, got.contended,
                 got.charge_mask);
      end
      return;
    end
    want = expected_results.pop_front();
    if (got.read_byte !== want.read_byte || got.video_valid !== want.video_valid ||
        got.video_byte !== want.video_byte || got.contended !== want.contended ||
        got.charge_mask !== want.charge_mask) begin
      fail_count++;
      if (reported < 10) begin
        reported++;
        $display("mismatch at %0t: exp rd=%h vwv=%b vwb=%h cont=%b mask=%h", $realtime,
                 want.read_byte, want.video_valid, want.video_byte, want.contended,
                 want.charge_mask);
        $display("                 got rd=%h vwv=%b vwb=%h cont=%b mask=%h",
                 got.read_byte, got.video_valid, got.video_byte, got.contended,
                 got.charge_mask);
      end
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_home_computer_bus_decoder_top;

  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
  localparam logic [KEY_W-1:0] KEYS_RELEASED = {KEY_W{1'b1}};
  localparam int               RANDOM_PER_PHASE = 94;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ADDR_W-1:0] ram_bytes_fitted = RAM_FITTED_RESET;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  req_type = REQ_INT_ACK;
  logic [ADDR_W-1:0] bus_address = '0;
  logic [BYTE_W-1:0] write_byte = '0;
  logic [KEY_W-1:0]  key_lines = KEYS_RELEASED;
  logic              ear_level = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] read_byte;
  logic              video_write_valid;
  logic [BYTE_W-1:0] video_write_byte;
  logic              contended_address;
  logic [MASK_W-1:0] port_charge_mask;

  bus_decode_scoreboard sb = new();
  bus_result_t          seen_word;
  logic [15:0]          ready_pattern = 16'hFFFF;
  int                   ready_age = 0;
  int                   burst_left = 0;

  home_computer_bus_decoder_top u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check result words and stall on a rotating pattern, reloaded now and then.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_word.read_byte   = read_byte;
      seen_word.video_valid = video_write_valid;
      seen_word.video_byte  = video_write_byte;
      seen_word.contended   = contended_address;
      seen_word.charge_mask = port_charge_mask;
      sb.check_result(seen_word);
    end
    if (ready_age == 0) begin
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
      ready_age     <= 47;
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      ready_age     <= ready_age - 1;
    end
    out_ready <= ready_pattern[0];
  end

  task automatic send_access(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] wbyte, input logic [KEY_W-1:0] keys,
                             input logic ear);
    int gap;
    in_valid    <= 1'b1;
    req_type    <= req;
    bus_address <= addr;
    write_byte  <= wbyte;
    key_lines   <= keys;
    ear_level   <= ear;
    do @(posedge clk); while (!in_ready);
    sb.note_access(req, addr, wbyte, keys, ear);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ram_fitted(input logic [ADDR_W-1:0] value);
    cfg_valid        <= 1'b1;
    ram_bytes_fitted <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    sb.ram_fitted = value;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address(input int lo_cat, input int hi_cat);
    int pick;
    case ($urandom_range(hi_cat, lo_cat))
      0: pick = $urandom_range(0, 63);
      1: pick = ROM_BYTES - 1 - int'($urandom_range(0, 31));
      2: pick = RAM_BASE + int'($urandom_range(0, 63));
      3: pick = RAM_BASE + int'(sb.ram_fitted) - 32 + int'($urandom_range(0, 63));
      4: pick = 65535 - int'($urandom_range(0, 63));
      5: pick = RAM_BASE + CONTENDED_BYTES - 32 + int'($urandom_range(0, 63));
      default: pick = $urandom_range(0, 65535);
    endcase
    return ADDR_W'(pick);
  endfunction

  function automatic logic [KEY_W-1:0] pick_keys();
    case ($urandom_range(0, 5))
      0: return KEYS_RELEASED;
      1: return ~(KEY_W'(1) << $urandom_range(0, KEY_W - 1));
      2: return '0;
      default: return KEY_W'({$urandom, $urandom});
    endcase
  endfunction

  task automatic send_random_access();
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) req = REQ_ROM_LOAD;
    else if (roll < 35) req = REQ_MEM_WRITE;
    else if (roll < 65) req = REQ_MEM_READ;
    else if (roll < 78) req = REQ_IO_READ;
    else if (roll < 90) req = REQ_IO_WRITE;
    else if (roll < 96) req = REQ_INT_ACK;
    else if (roll < 98) req = REQ_SPARE_LO;
    else req = REQ_SPARE_HI;
    if (req == REQ_ROM_LOAD && $urandom_range(0, 3) != 0) addr = pick_address(0, 1);
    else if (req == REQ_MEM_WRITE && $urandom_range(0, 3) != 0) addr = pick_address(2, 5);
    else addr = pick_address(0, 7);
    if (req == REQ_IO_READ || req == REQ_IO_WRITE) begin
      if ($urandom_range(0, 3) != 0) addr[0] = 1'b0;
      // single half-row selects make the key bits visible
      if (req == REQ_IO_READ && $urandom_range(0, 2) == 0)
        addr[15:8] = ~(8'd1 << $urandom_range(0, 7));
    end
    // never read a byte that was not stored yet
    if (req == REQ_MEM_READ && sb.read_hits_blank(addr)) begin
      if (!sb.stored_address(addr)) req = REQ_MEM_WRITE;
    end
    send_access(req, addr, BYTE_W'($urandom), pick_keys(), 1'($urandom));
  endtask

  initial begin
    logic [ADDR_W-1:0] fitted_plan [$];
    fitted_plan = '{16'd0, 16'd1, 16'd4096, 16'($urandom_range(2, 49150)), 16'd16383,
                    16'd16384, 16'd49151, RAM_FITTED_RESET};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_ram_fitted(RAM_FITTED_RESET);

    send_access(REQ_ROM_LOAD, 16'h0000, 8'h00, KEYS_RELEASED, 1'b0);
    send_access(REQ_ROM_LOAD, ADDR_W'(ROM_BYTES - 1), 8'hFF, KEYS_RELEASED, 1'b1);
    send_access(REQ_ROM_LOAD, ADDR_W'(ROM_BYTES), 8'h5A, '0, 1'b0);
    send_access(REQ_ROM_LOAD, 16'hFFFF, 8'hC3, '0, 1'b1);
    send_access(REQ_MEM_READ, 16'h0000, 8'hFF, KEYS_RELEASED, 1'b0);
    send_access(REQ_MEM_READ, ADDR_W'(ROM_BYTES - 1), 8'h00, '0, 1'b1);
    send_access(REQ_MEM_WRITE, ADDR_W'(RAM_BASE), 8'hA5, KEYS_RELEASED, 1'b0);
    send_access(REQ_MEM_WRITE, 16'hFFFF, 8'h3C, KEYS_RELEASED, 1'b0);
    send_access(REQ_MEM_READ, ADDR_W'(RAM_BASE), 8'h00, KEYS_RELEASED, 1'b0);
    send_access(REQ_MEM_READ, 16'hFFFF, 8'h00, KEYS_RELEASED, 1'b0);
    // writes into ROM must leave it untouched
    send_access(REQ_MEM_WRITE, 16'h0000, 8'h77, KEYS_RELEASED, 1'b0);
    send_access(REQ_MEM_READ, 16'h0000, 8'h00, KEYS_RELEASED, 1'b0);
    send_access(REQ_IO_READ, 16'hFFFE, 8'h00, KEYS_RELEASED, 1'b0);
    send_access(REQ_IO_READ, 16'hFFFE, 8'h00, KEYS_RELEASED, 1'b1);
    send_access(REQ_IO_READ, 16'h00FE, 8'h00, '0, 1'b0);
    send_access(REQ_IO_READ, 16'hFEFE, 8'h00, ~(KEY_W'(1) << 3), 1'b1);
    send_access(REQ_IO_READ, 16'h7FFE, 8'h00, ~(KEY_W'(1) << 37), 1'b0);
    send_access(REQ_IO_READ, 16'h00FF, 8'h00, '0, 1'b1);
    send_access(REQ_IO_WRITE, 16'h00FE, 8'h00, KEYS_RELEASED, 1'b0);
    send_access(REQ_IO_WRITE, 16'hFFFE, 8'hFF, KEYS_RELEASED, 1'b0);
    send_access(REQ_IO_WRITE, 16'h40FF, 8'h81, KEYS_RELEASED, 1'b0);
    send_access(REQ_INT_ACK, ADDR_W'(RAM_BASE + CONTENDED_BYTES - 1), 8'h00, '0, 1'b0);
    send_access(REQ_INT_ACK, ADDR_W'(RAM_BASE + CONTENDED_BYTES), 8'h00, '0, 1'b0);
    send_access(REQ_SPARE_LO, 16'h4001, 8'h12, '0, 1'b1);
    send_access(REQ_SPARE_HI, 16'h8000, 8'hED, KEYS_RELEASED, 1'b0);
    wait_idle();

    foreach (fitted_plan[i]) begin
      write_ram_fitted(fitted_plan[i]);
      repeat (RANDOM_PER_PHASE) send_random_access();
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("** home_computer_bus_decoder_top: PASSED **");
    end else begin
      $display("** home_computer_bus_decoder_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout waiting for the bus decoder");
    $display("** home_computer_bus_decoder_top: FAILED **");
    $finish;
  end

endmodule
